FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/fde_pkg.sv
// ----------------------------------------------------------------------------
// fde_pkg
// Types and constants of the FAT32 short-name directory search.
// ----------------------------------------------------------------------------
`default_nettype none

package fde_pkg;

   // Directory entry layout
   localparam logic [7:0] BYTE_DELETED = 8'hE5;
   localparam logic [7:0] BYTE_END     = 8'h00;
   localparam logic [7:0] ATTR_LFN     = 8'h0F;
   localparam logic [7:0] ATTR_VOLUME  = 8'h08;
   localparam int         ENTRY_BYTES  = 32;
   localparam int         NAME_BYTES   = 11;
   localparam int         OFF_W        = $clog2(ENTRY_BYTES);

   localparam logic [OFF_W-1:0] OFF_ATTR     = OFF_W'(NAME_BYTES);
   localparam logic [OFF_W-1:0] OFF_CLHI_LO  = OFF_W'(20);
   localparam logic [OFF_W-1:0] OFF_CLHI_HI  = OFF_W'(21);
   localparam logic [OFF_W-1:0] OFF_CLLO_LO  = OFF_W'(26);
   localparam logic [OFF_W-1:0] OFF_CLLO_HI  = OFF_W'(27);
   localparam logic [OFF_W-1:0] OFF_SIZE     = OFF_W'(28);
   localparam logic [OFF_W-1:0] OFF_LAST     = OFF_W'(ENTRY_BYTES - 1);

   // Result status codes
   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_END       = 2'd1;
   localparam logic [1:0] ST_EXHAUSTED = 2'd2;

   // Register address width; address bit 3 selects the register
   localparam int ADDR_W = 4;

   typedef struct packed {
      logic [7:0] dir_byte;
      logic       first_byte;
      logic       dir_last;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  attr;
      logic [31:0] start_cluster;
      logic [31:0] file_size;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/fde_csr.sv
// ----------------------------------------------------------------------------
// fde_csr
// APB register file holding the 11-byte 8.3 target name.
// ----------------------------------------------------------------------------
`default_nettype none

module fde_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [fde_pkg::ADDR_W-1:0]    csr_paddr,
   input  wire logic [63:0]                   csr_pwdata,
   output logic      [63:0]                   csr_prdata,
   output logic                               csr_pready,
   output logic      [63:0]                   target_lo,
   output logic      [23:0]                   target_hi
);

   logic [63:0] name_lo_ff;
   logic [23:0] name_hi_ff;
   logic        wr_en;
   logic        sel_hi;

   // Decode the write; address bit 3 picks the register
   assign wr_en  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign sel_hi = csr_paddr[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         name_lo_ff <= '0;
         name_hi_ff <= '0;
      end else if (wr_en) begin
         if (sel_hi) begin
            name_hi_ff <= csr_pwdata[23:0];
         end else begin
            name_lo_ff <= csr_pwdata;
         end
      end
   end

   // Read back and drive the target
   assign csr_prdata = sel_hi ? {40'd0, name_hi_ff} : name_lo_ff;
   assign csr_pready = 1'b1;
   assign target_lo  = name_lo_ff;
   assign target_hi  = name_hi_ff;

endmodule

`default_nettype wire

FILE: design/fde_scan.sv
// ----------------------------------------------------------------------------
// fde_scan
// Entry parser: tracks the offset inside the 32-byte entry, compares the
// name, captures attribute, cluster and size, and decides the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fde_scan (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             item_valid,
   input  wire fde_pkg::req_type item,
   input  wire logic [63:0]      target_lo,
   input  wire logic [23:0]      target_hi,
   output logic                  res_valid,
   output fde_pkg::rsp_type      res
);

   localparam int OW = fde_pkg::OFF_W;

   logic [OW-1:0] offset_ff,   offset_in;
   logic          name_eq_ff,  name_eq_in;
   logic          skip_ff,     skip_in;
   logic [7:0]    attr_ff,     attr_in;
   logic [15:0]   clhi_ff,     clhi_in;
   logic [15:0]   cllo_ff,     cllo_in;
   logic [31:0]   size_ff,     size_in;
   logic          done_ff,     done_in;

   logic [OW-1:0] off;
   logic          eq_cur, skip_cur, done_cur;
   logic [7:0]    attr_cur;
   logic [15:0]   clhi_cur, cllo_cur;
   logic [31:0]   size_cur;

   logic          eq_n, skip_n;
   logic [7:0]    attr_n;
   logic [15:0]   clhi_n, cllo_n;
   logic [31:0]   size_n;

   logic [127:0]  target_vec;
   logic [7:0]    tgt_byte;
   logic [7:0]    b;
   logic          end_hit, entry_end, found;

   assign b = item.dir_byte;

   // Apply a restart before anything else
   always_comb begin
      if (item.first_byte) begin
         off      = '0;
         eq_cur   = 1'b1;
         skip_cur = 1'b0;
         attr_cur = '0;
         clhi_cur = '0;
         cllo_cur = '0;
         size_cur = '0;
         done_cur = 1'b0;
      end else begin
         off      = offset_ff;
         eq_cur   = name_eq_ff;
         skip_cur = skip_ff;
         attr_cur = attr_ff;
         clhi_cur = clhi_ff;
         cllo_cur = cllo_ff;
         size_cur = size_ff;
         done_cur = done_ff;
      end
   end

   // Pick the target byte for this offset
   assign target_vec = {40'd0, target_hi, target_lo};
   assign tgt_byte   = target_vec[{off[3:0], 3'b000} +: 8];

   // Update the entry fields with this byte
   always_comb begin
      eq_n   = eq_cur;
      skip_n = skip_cur;
      attr_n = attr_cur;
      clhi_n = clhi_cur;
      cllo_n = cllo_cur;
      size_n = size_cur;
      if (off == '0 && b == fde_pkg::BYTE_DELETED) begin
         skip_n = 1'b1;
      end
      if (off < fde_pkg::OFF_ATTR && b != tgt_byte) begin
         eq_n = 1'b0;
      end
      if (off == fde_pkg::OFF_ATTR) begin
         attr_n = b;
         if (b == fde_pkg::ATTR_LFN || (b & fde_pkg::ATTR_VOLUME) != 8'd0) begin
            skip_n = 1'b1;
         end
      end
      if (off == fde_pkg::OFF_CLHI_LO) clhi_n[7:0]  = b;
      if (off == fde_pkg::OFF_CLHI_HI) clhi_n[15:8] = b;
      if (off == fde_pkg::OFF_CLLO_LO) cllo_n[7:0]  = b;
      if (off == fde_pkg::OFF_CLLO_HI) cllo_n[15:8] = b;
      if (off >= fde_pkg::OFF_SIZE) begin
         size_n[{off[1:0], 3'b000} +: 8] = b;
      end
   end

   assign end_hit   = (off == '0) && (b == fde_pkg::BYTE_END);
   assign entry_end = (off == fde_pkg::OFF_LAST);
   assign found     = entry_end && eq_n && !skip_n;

   // Decide the next state and the result
   always_comb begin
      offset_in = off;
      name_eq_in = eq_cur;
      skip_in   = skip_cur;
      attr_in   = attr_cur;
      clhi_in   = clhi_cur;
      cllo_in   = cllo_cur;
      size_in   = size_cur;
      done_in   = done_cur;
      res_valid = 1'b0;
      res       = '0;
      if (!done_cur) begin
         if (end_hit) begin
            done_in    = 1'b1;
            res_valid  = item_valid;
            res.status = fde_pkg::ST_END;
         end else if (found) begin
            name_eq_in        = eq_n;
            skip_in           = skip_n;
            attr_in           = attr_n;
            clhi_in           = clhi_n;
            cllo_in           = cllo_n;
            size_in           = size_n;
            done_in           = 1'b1;
            res_valid         = item_valid;
            res.status        = fde_pkg::ST_FOUND;
            res.attr          = attr_n;
            res.start_cluster = {clhi_n, cllo_n};
            res.file_size     = size_n;
         end else begin
            if (entry_end) begin
               offset_in  = '0;
               name_eq_in = 1'b1;
               skip_in    = 1'b0;
               attr_in    = '0;
               clhi_in    = '0;
               cllo_in    = '0;
               size_in    = '0;
            end else begin
               offset_in  = off + OW'(1);
               name_eq_in = eq_n;
               skip_in    = skip_n;
               attr_in    = attr_n;
               clhi_in    = clhi_n;
               cllo_in    = cllo_n;
               size_in    = size_n;
            end
            if (item.dir_last) begin
               done_in    = 1'b1;
               res_valid  = item_valid;
               res.status = fde_pkg::ST_EXHAUSTED;
            end
         end
      end
   end

   // Advance the state on each consumed request
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= '0;
         name_eq_ff <= 1'b1;
         skip_ff    <= 1'b0;
         attr_ff    <= '0;
         clhi_ff    <= '0;
         cllo_ff    <= '0;
         size_ff    <= '0;
         done_ff    <= 1'b0;
      end else if (item_valid) begin
         offset_ff  <= offset_in;
         name_eq_ff <= name_eq_in;
         skip_ff    <= skip_in;
         attr_ff    <= attr_in;
         clhi_ff    <= clhi_in;
         cllo_ff    <= cllo_in;
         size_ff    <= size_in;
         done_ff    <= done_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/fat_dir_entry_match.sv
// A request is held in the input register; its result is registered in the result register once it advances.
// Throughput: one directory byte per cycle, back to back while rsp_ready stays high.
// While a result waits the input register still takes one request; requests back up
// only once both the input and the result register are full.
// Reset (synchronous, active high) clears both valid bits, the entry state and the
// target name; the block then accepts bytes as if a search had just begun.
`default_nettype none
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// fat_dir_entry_match
// FAT32 short-name directory search: one byte per request, reports the first
// matching 8.3 entry, the end marker or the end of the directory.
// ----------------------------------------------------------------------------
module fat_dir_entry_match (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire fde_pkg::req_type           req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output fde_pkg::rsp_type                rsp_data,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [fde_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [63:0]                csr_pwdata,
   output logic      [63:0]                csr_prdata,
   output logic                            csr_pready
);

   logic             in_valid_ff, in_valid_in;
   fde_pkg::req_type in_data_ff;
   logic             out_valid_ff, out_valid_in;
   fde_pkg::rsp_type out_data_ff;
   logic             advance;
   logic             res_valid;
   fde_pkg::rsp_type res;
   logic [63:0]      target_lo;
   logic [23:0]      target_hi;

   fde_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .target_lo   (target_lo),
      .target_hi   (target_hi)
   );

   // Consume the held request once the result register is free or drains
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   fde_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (in_data_ff),
      .target_lo  (target_lo),
      .target_hi  (target_hi),
      .res_valid  (res_valid),
      .res        (res)
   );

   // Hold the incoming request
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Hold the result until it is taken
   always_comb begin
      if (advance) begin
         out_valid_in = res_valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_data_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Checks
   `ASSERT_SAME(a_res_only_on_advance, clock, reset, res_valid, advance)
   `ASSERT_SAME(a_status_legal, clock, reset, rsp_valid,
      rsp_data.status == fde_pkg::ST_FOUND || rsp_data.status == fde_pkg::ST_END ||
      rsp_data.status == fde_pkg::ST_EXHAUSTED)
   `ASSERT_SAME(a_notfound_zero, clock, reset,
      rsp_valid && rsp_data.status != fde_pkg::ST_FOUND,
      rsp_data.attr == 8'd0 && rsp_data.start_cluster == 32'd0 && rsp_data.file_size == 32'd0)
   `ASSERT_NEXT(a_stalled_item_held, clock, reset, in_valid_ff && !advance, in_valid_ff)

endmodule

`default_nettype wire
